/* sv/frpsnr_pkg.sv */
// ----------------------------------------------------------------------------
// frpsnr_pkg
// Shared types and constants of the frame PSNR meter.
// ----------------------------------------------------------------------------
package frpsnr_pkg;

  localparam int ErrW = 56;
  localparam int LogFrac = 24;
  localparam int LogW = 30;
  localparam int CfgW = 13;
  localparam int SampleW = 16;
  localparam logic [31:0] TenLog10Two = 32'd3232284966;
  localparam logic [ErrW-1:0] ErrMax = {ErrW{1'b1}};

  localparam logic RegFrameWidth = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOGP,
    BK_LOGE,
    BK_MUL,
    BK_RND,
    BK_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ,
    LG_DONE
  } log_state_e;

  typedef struct packed {
    logic            done;
    logic [LogW-1:0] result;
  } log_status_t;

endpackage

/* sv/frpsnr_front.sv */
// ----------------------------------------------------------------------------
// frpsnr_front
// Squares sample differences, accumulates the error sum and counts pixels;
// hands one job to the queue at the end of each frame.
// ----------------------------------------------------------------------------
module frpsnr_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int PIX_W = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [frpsnr_pkg::SampleW-1:0] sample_a_i,
  input  logic [frpsnr_pkg::SampleW-1:0] sample_b_i,
  input  logic [PIX_W-1:0]             pixels_i,
  input  logic [1:0]                   jq_count_i,
  output logic                         full_o,
  output logic                         job_push_o,
  output logic [frpsnr_pkg::ErrW-1:0]  job_err_o,
  output logic [PIX_W-1:0]             job_pix_o
);

  localparam logic [frpsnr_pkg::SampleW-1:0] SMask =
    frpsnr_pkg::SampleW'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [frpsnr_pkg::SampleW-1:0] a_m, b_m, diff;
  logic [PIX_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             last;
  logic [2*frpsnr_pkg::SampleW-1:0] sq_q;
  logic             s1_valid_q, s1_last_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [frpsnr_pkg::ErrW-1:0] err_q, err_d, err_sat;
  logic [frpsnr_pkg::ErrW:0]   err_sum;

  assign a_m = sample_a_i & SMask;
  assign b_m = sample_b_i & SMask;
  assign diff = (a_m >= b_m) ? (a_m - b_m) : (b_m - a_m);
  assign cnt_next = cnt_q + PIX_W'(1);
  assign last = cnt_next >= pixels_i;

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = last ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q <= 1'b0;
      err_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      s1_valid_q <= accept_i;
      s1_last_q <= accept_i & last;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sq_q <= diff * diff;
      s1_pix_q <= pixels_i;
    end
  end

  assign err_sum = {1'b0, err_q} + (frpsnr_pkg::ErrW + 1)'(sq_q);
  assign err_sat = err_sum[frpsnr_pkg::ErrW] ? frpsnr_pkg::ErrMax
                                             : err_sum[frpsnr_pkg::ErrW-1:0];

  always_comb begin
    err_d = err_q;
    if (s1_valid_q) begin
      err_d = s1_last_q ? '0 : err_sat;
    end
  end

  assign job_push_o = s1_valid_q & s1_last_q;
  assign job_err_o = err_sat;
  assign job_pix_o = s1_pix_q;
  assign full_o = (jq_count_i == 2'd2) || ((jq_count_i == 2'd1) && s1_valid_q && s1_last_q);

endmodule

/* sv/frpsnr_jobq.sv */
// ----------------------------------------------------------------------------
// frpsnr_jobq
// Two-entry queue of finished frame totals between the front and back parts.
// ----------------------------------------------------------------------------
module frpsnr_jobq #(
  parameter int PIX_W = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [frpsnr_pkg::ErrW-1:0] err_i,
  input  logic [PIX_W-1:0]            pix_i,
  input  logic                        pop_i,
  output logic [1:0]                  count_o,
  output logic [frpsnr_pkg::ErrW-1:0] err_o,
  output logic [PIX_W-1:0]            pix_o
);

  logic [frpsnr_pkg::ErrW-1:0] err_mem [2];
  logic [PIX_W-1:0]            pix_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      err_mem[wr_q] <= err_i;
      pix_mem[wr_q] <= pix_i;
    end
  end

  assign count_o = cnt_q;
  assign err_o = err_mem[rd_q];
  assign pix_o = pix_mem[rd_q];

endmodule

/* sv/frpsnr_log2.sv */
// ----------------------------------------------------------------------------
// frpsnr_log2
// Iterative base-two logarithm in Q.24: one normalising shift per cycle, then
// one mantissa squaring per cycle for each fraction bit.
// ----------------------------------------------------------------------------
module frpsnr_log2 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              x_i,
  output frpsnr_pkg::log_status_t  status_o
);

  frpsnr_pkg::log_state_e state_q, state_d;
  logic [63:0] x_q;
  logic [5:0]  e_q;
  logic [31:0] m_q;
  logic [frpsnr_pkg::LogFrac-1:0] r_q;
  logic [4:0]  i_q;
  logic [63:0] prod;

  assign prod = m_q * m_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      frpsnr_pkg::LG_IDLE: begin
        if (start_i) begin
          state_d = frpsnr_pkg::LG_NORM;
        end
      end
      frpsnr_pkg::LG_NORM: begin
        if (x_q[63]) begin
          state_d = frpsnr_pkg::LG_SQ;
        end
      end
      frpsnr_pkg::LG_SQ: begin
        if (i_q == 5'd0) begin
          state_d = frpsnr_pkg::LG_DONE;
        end
      end
      frpsnr_pkg::LG_DONE: begin
        if (start_i) begin
          state_d = frpsnr_pkg::LG_NORM;
        end else begin
          state_d = frpsnr_pkg::LG_IDLE;
        end
      end
      default: state_d = frpsnr_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frpsnr_pkg::LG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      frpsnr_pkg::LG_IDLE, frpsnr_pkg::LG_DONE: begin
        x_q <= x_i;
        e_q <= 6'd63;
      end
      frpsnr_pkg::LG_NORM: begin
        if (x_q[63]) begin
          m_q <= x_q[63:32];
          i_q <= 5'(frpsnr_pkg::LogFrac - 1);
        end else begin
          x_q <= {x_q[62:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
      end
      frpsnr_pkg::LG_SQ: begin
        m_q <= prod[63] ? prod[63:32] : prod[62:31];
        r_q <= {r_q[frpsnr_pkg::LogFrac-2:0], prod[63]};
        i_q <= i_q - 5'd1;
      end
      default: begin
      end
    endcase
  end

  assign status_o.done = (state_q == frpsnr_pkg::LG_DONE);
  assign status_o.result = {e_q, r_q};

endmodule

/* sv/frpsnr_back.sv */
// ----------------------------------------------------------------------------
// frpsnr_back
// Turns one frame's error sum and pixel count into PSNR in Q8.8 dB and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module frpsnr_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int PIX_W = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  logic [frpsnr_pkg::ErrW-1:0] job_err_i,
  input  logic [PIX_W-1:0]            job_pix_i,
  output logic                        job_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [15:0]                 psnr_db_o,
  output logic                        is_infinite_o
);

  localparam logic [31:0] NumOffset = 32'((2 * SAMPLE_BITS) << frpsnr_pkg::LogFrac);

  frpsnr_pkg::back_state_e state_q, state_d;
  frpsnr_pkg::log_status_t lg_status;
  logic        lg_start;
  logic [63:0] lg_x;
  logic [frpsnr_pkg::ErrW-1:0] err_q;
  logic [frpsnr_pkg::LogW-1:0] logp_q;
  logic [31:0] num, diff_q;
  logic [63:0] prod_q;
  logic [17:0] rnd;
  logic [15:0] q_q;
  logic        inf_q;
  logic        res_valid_q, res_load;
  logic [15:0] res_psnr_q;
  logic        res_inf_q;

  frpsnr_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .status_o(lg_status)
  );

  assign num = 32'(logp_q) + NumOffset;
  assign rnd = 18'((prod_q + (64'd1 << 45)) >> 46);

  always_comb begin
    state_d = state_q;
    lg_start = 1'b0;
    lg_x = 64'(job_pix_i);
    job_pop_o = 1'b0;
    res_load = 1'b0;
    case (state_q)
      frpsnr_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_err_i == '0) begin
            state_d = frpsnr_pkg::BK_OUT;
          end else begin
            lg_start = 1'b1;
            state_d = frpsnr_pkg::BK_LOGP;
          end
        end
      end
      frpsnr_pkg::BK_LOGP: begin
        lg_x = 64'(err_q);
        if (lg_status.done) begin
          lg_start = 1'b1;
          state_d = frpsnr_pkg::BK_LOGE;
        end
      end
      frpsnr_pkg::BK_LOGE: begin
        if (lg_status.done) begin
          state_d = (num <= 32'(lg_status.result)) ? frpsnr_pkg::BK_OUT
                                                   : frpsnr_pkg::BK_MUL;
        end
      end
      frpsnr_pkg::BK_MUL: state_d = frpsnr_pkg::BK_RND;
      frpsnr_pkg::BK_RND: state_d = frpsnr_pkg::BK_OUT;
      frpsnr_pkg::BK_OUT: begin
        if (!res_valid_q || pop_i) begin
          res_load = 1'b1;
          state_d = frpsnr_pkg::BK_IDLE;
        end
      end
      default: state_d = frpsnr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frpsnr_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      frpsnr_pkg::BK_IDLE: begin
        err_q <= job_err_i;
        q_q <= '0;
        inf_q <= (job_err_i == '0);
      end
      frpsnr_pkg::BK_LOGP: begin
        if (lg_status.done) begin
          logp_q <= lg_status.result;
        end
      end
      frpsnr_pkg::BK_LOGE: begin
        diff_q <= num - 32'(lg_status.result);
      end
      frpsnr_pkg::BK_MUL: begin
        prod_q <= 64'(diff_q) * 64'(frpsnr_pkg::TenLog10Two);
      end
      frpsnr_pkg::BK_RND: begin
        q_q <= (rnd > 18'd65535) ? 16'hFFFF : rnd[15:0];
      end
      default: begin
      end
    endcase
    if (res_load) begin
      res_psnr_q <= q_q;
      res_inf_q <= inf_q;
    end
  end

  assign empty_o = ~res_valid_q;
  assign psnr_db_o = res_psnr_q;
  assign is_infinite_o = res_inf_q;

endmodule

/* sv/frame_psnr_meter_core.sv */
// ----------------------------------------------------------------------------
// frame_psnr_meter_core
// PSNR of two frames fed as co-located sample pairs in raster order.
//
//   Channel   Handshake           Payload
//   input     push / full         sample_a_i, sample_b_i
//   result    empty / pop         psnr_db_o, is_infinite_o
//   config    cfg_we_i            cfg_index_i, cfg_data_i
//
// One sample pair is taken per cycle while the frame job queue has room.
// At the end of a frame the back part runs the shared log unit twice, first
// on the pixel count, then on the error sum, unless the error sum is zero.
// Two finished frames may wait in the queue, so short frames stall push.
// Reset sets width and height to one and clears both accumulators.
// ----------------------------------------------------------------------------
module frame_psnr_meter_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [frpsnr_pkg::SampleW-1:0] sample_a_i,
  input  logic [frpsnr_pkg::SampleW-1:0] sample_b_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [15:0]                    psnr_db_o,
  output logic                           is_infinite_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [frpsnr_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int WdW = $clog2(MAX_WIDTH + 1);
  localparam int HtW = $clog2(MAX_HEIGHT + 1);
  localparam int PixW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [frpsnr_pkg::CfgW-1:0] width_q, height_q;
  logic [WdW-1:0]  cw;
  logic [HtW-1:0]  ch;
  logic [PixW-1:0] pixels;
  logic            accept;
  logic [1:0]      jq_count;
  logic            job_push, job_pop;
  logic [frpsnr_pkg::ErrW-1:0] job_err, jq_err;
  logic [PixW-1:0] job_pix, jq_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= frpsnr_pkg::CfgW'(1);
      height_q <= frpsnr_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == frpsnr_pkg::RegFrameWidth) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      cw = WdW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      cw = WdW'(MAX_WIDTH);
    end else begin
      cw = WdW'(width_q);
    end
    if (height_q == '0) begin
      ch = HtW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      ch = HtW'(MAX_HEIGHT);
    end else begin
      ch = HtW'(height_q);
    end
  end

  assign pixels = PixW'(cw * ch);
  assign accept = push & ~full;

  frpsnr_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PIX_W      (PixW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_a_i(sample_a_i),
    .sample_b_i(sample_b_i),
    .pixels_i  (pixels),
    .jq_count_i(jq_count),
    .full_o    (full),
    .job_push_o(job_push),
    .job_err_o (job_err),
    .job_pix_o (job_pix)
  );

  frpsnr_jobq #(
    .PIX_W(PixW)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .err_i  (job_err),
    .pix_i  (job_pix),
    .pop_i  (job_pop),
    .count_o(jq_count),
    .err_o  (jq_err),
    .pix_o  (jq_pix)
  );

  frpsnr_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PIX_W      (PixW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (jq_count != 2'd0),
    .job_err_i    (jq_err),
    .job_pix_i    (jq_pix),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .psnr_db_o    (psnr_db_o),
    .is_infinite_o(is_infinite_o)
  );

endmodule
